/* rtl/fbfl_pkg.sv */
`timescale 1ns / 1ps

package fbfl_pkg;

  localparam int ADDR_W     = 32;
  localparam int BS_W       = 13;
  localparam int NB_W       = 9;
  localparam int FC_W       = 9;
  localparam int ST_W       = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_BLOCKS_DEF = 256;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOMEM     = 3'd1;
  localparam logic [ST_W-1:0] ST_UNALIGNED = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [ST_W-1:0] ST_DOUBLE    = 3'd4;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SIZE  = 2'd3;

  localparam logic [BS_W-1:0]   BLOCK_SIZE_RST   = 13'd64;
  localparam logic [NB_W-1:0]   NUM_BLOCKS_RST   = 9'd256;
  localparam logic [ADDR_W-1:0] BASE_ADDRESS_RST = 32'd0;
  localparam logic [ADDR_W-1:0] MEMORY_SIZE_RST  = 32'd17408;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] release_address;
  } fbfl_req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] block_address;
    logic [FC_W-1:0]   free_count;
  } fbfl_rsp_t;

endpackage

/* rtl/fixed_block_free_list_allocator.sv */
`timescale 1ns / 1ps

// Fixed-size block allocator. A command beat is taken when start is high and
// busy is low; its single result appears on response for exactly one cycle
// with done high, and the receiver cannot stall it, so it must take every
// beat as it comes. Allocate reads and then writes the link memory, or
// answers without a memory access when the pool is empty. Release waits, when
// block_size is nonzero, on the 32-step divider that turns the byte offset
// into a block index, and skips it when block_size is zero. Initialize does a
// multiply and compare for the memory check, then a sweep that rewrites the
// link memory one entry per cycle; it ends after the compare when the memory
// check fails. After reset the same sweep runs with busy high before the
// first command is taken; configuration writes are accepted at any time but
// belong between commands.
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  fbfl_pkg::fbfl_req_t            request,
  output logic                           done,
  output fbfl_pkg::fbfl_rsp_t            response,
  input  logic                           cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fbfl_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int ENT_W   = IDX_W + 2;
  localparam int END_B   = IDX_W;
  localparam int DET_B   = IDX_W + 1;
  localparam int AOFF_W  = IDX_W + BS_W;
  localparam int NEED_W  = NB_W + BS_W + 1;
  localparam int RST_POOL = (int'(NUM_BLOCKS_RST) > MAX_BLOCKS) ? MAX_BLOCKS
                                                                 : int'(NUM_BLOCKS_RST);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SWEEP    = 4'd1;
  localparam logic [3:0] S_INIT_MUL = 4'd2;
  localparam logic [3:0] S_INIT_CHK = 4'd3;
  localparam logic [3:0] S_ALLOC_RD = 4'd4;
  localparam logic [3:0] S_REL_PREP = 4'd5;
  localparam logic [3:0] S_DIV      = 4'd6;
  localparam logic [3:0] S_REL_RD   = 4'd7;

  logic [BS_W-1:0]   block_size;
  logic [NB_W-1:0]   num_blocks;
  logic [ADDR_W-1:0] base_address;
  logic [ADDR_W-1:0] memory_size;

  logic [3:0]        state, state_next;
  logic [IDX_W-1:0]  head_index, head_index_next;
  logic              head_valid, head_valid_next;
  logic [FC_W-1:0]   free_blocks, free_blocks_next;
  logic [IDX_W-1:0]  sweep_ptr, sweep_ptr_next;
  logic [NB_W-1:0]   sweep_n, sweep_n_next;
  logic              sweep_init, sweep_init_next;
  logic [NEED_W-1:0] need, need_next;
  logic [AOFF_W-1:0] aoff, aoff_next;
  logic [ADDR_W-1:0] offs, offs_next;
  logic              rel_neg, rel_neg_next;
  logic [IDX_W-1:0]  rel_idx, rel_idx_next;
  logic              done_next;
  fbfl_rsp_t         rsp_next;

  logic [NB_W-1:0]   pool_live;
  logic [ADDR_W-1:0] mag;
  logic [IDX_W-1:0]  sweep_link;
  logic              sweep_end;

  logic              chk_go;
  logic              chk_unal;
  logic              chk_neg;
  logic [ADDR_W-1:0] chk_idx;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENT_W-1:0]  mem_rdata;

  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quo;
  logic [BS_W-1:0]   div_rem;

  fbfl_mem #(
    .DEPTH(MAX_BLOCKS),
    .AW   (IDX_W),
    .DW   (ENT_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  fbfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (block_size),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= BLOCK_SIZE_RST;
      num_blocks   <= NUM_BLOCKS_RST;
      base_address <= BASE_ADDRESS_RST;
      memory_size  <= MEMORY_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size   <= cfg_data[BS_W-1:0];
        REG_NUM_BLOCKS:   num_blocks   <= cfg_data[NB_W-1:0];
        REG_BASE_ADDRESS: base_address <= cfg_data[ADDR_W-1:0];
        REG_MEMORY_SIZE:  memory_size  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(num_blocks) > 32'(MAX_BLOCKS)) begin
      pool_live = NB_W'(MAX_BLOCKS);
    end else begin
      pool_live = num_blocks;
    end
    mag        = offs[ADDR_W-1] ? (~offs + ADDR_W'(1)) : offs;
    sweep_end  = (32'(sweep_ptr) + 32'd1 == 32'(sweep_n));
    sweep_link = (32'(sweep_ptr) + 32'd1 < 32'(sweep_n)) ? (sweep_ptr + IDX_W'(1)) : '0;
  end

  always_comb begin
    state_next       = state;
    head_index_next  = head_index;
    head_valid_next  = head_valid;
    free_blocks_next = free_blocks;
    sweep_ptr_next   = sweep_ptr;
    sweep_n_next     = sweep_n;
    sweep_init_next  = sweep_init;
    need_next        = need;
    aoff_next        = aoff;
    offs_next        = offs;
    rel_neg_next     = rel_neg;
    rel_idx_next     = rel_idx;
    done_next        = 1'b0;
    rsp_next         = '0;
    rsp_next.status  = ST_OK;
    mem_we           = 1'b0;
    mem_waddr        = sweep_ptr;
    mem_wdata        = '0;
    mem_raddr        = head_index;
    div_start        = 1'b0;
    chk_go           = 1'b0;
    chk_unal         = 1'b0;
    chk_neg          = 1'b0;
    chk_idx          = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (request.command)
            CMD_ALLOC: begin
              if (!head_valid) begin
                done_next       = 1'b1;
                rsp_next.status = ST_EMPTY;
              end else begin
                aoff_next  = AOFF_W'(head_index) * AOFF_W'(block_size);
                state_next = S_ALLOC_RD;
              end
            end
            CMD_RELEASE: begin
              offs_next  = request.release_address - base_address;
              state_next = S_REL_PREP;
            end
            CMD_INIT: begin
              sweep_n_next = pool_live;
              state_next   = S_INIT_MUL;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        head_valid_next = !mem_rdata[END_B];
        head_index_next = mem_rdata[END_B] ? '0 : mem_rdata[IDX_W-1:0];
        mem_we          = 1'b1;
        mem_waddr       = head_index;
        mem_wdata       = {1'b1, 1'b0, {IDX_W{1'b0}}};
        if (free_blocks != '0) begin
          free_blocks_next = free_blocks - FC_W'(1);
        end
        done_next              = 1'b1;
        rsp_next.block_address = base_address + ADDR_W'(aoff);
        state_next             = S_IDLE;
      end
      S_REL_PREP: begin
        rel_neg_next = offs[ADDR_W-1];
        if (block_size == '0) begin
          chk_go   = 1'b1;
          chk_unal = (mag != '0);
          chk_neg  = offs[ADDR_W-1];
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          chk_go   = 1'b1;
          chk_unal = (div_rem != '0);
          chk_neg  = rel_neg;
          chk_idx  = div_quo;
        end
      end
      S_REL_RD: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (!mem_rdata[DET_B]) begin
          rsp_next.status = ST_DOUBLE;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = rel_idx;
          mem_wdata        = {1'b0, !head_valid, head_index};
          head_index_next  = rel_idx;
          head_valid_next  = 1'b1;
          free_blocks_next = free_blocks + FC_W'(1);
        end
      end
      S_INIT_MUL: begin
        need_next  = NEED_W'(sweep_n) * (NEED_W'(block_size) + NEED_W'(4));
        state_next = S_INIT_CHK;
      end
      S_INIT_CHK: begin
        if (memory_size < ADDR_W'(need)) begin
          done_next       = 1'b1;
          rsp_next.status = ST_NOMEM;
          state_next      = S_IDLE;
        end else begin
          sweep_ptr_next  = '0;
          sweep_init_next = 1'b1;
          state_next      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_ptr;
        mem_wdata      = {1'b0, sweep_end, sweep_link};
        sweep_ptr_next = sweep_ptr + IDX_W'(1);
        if (sweep_ptr == IDX_W'(MAX_BLOCKS - 1)) begin
          state_next = S_IDLE;
          if (sweep_init) begin
            head_index_next  = '0;
            head_valid_next  = (sweep_n != '0);
            free_blocks_next = FC_W'(sweep_n);
            done_next        = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (chk_go) begin
      if (chk_unal) begin
        done_next       = 1'b1;
        rsp_next.status = ST_UNALIGNED;
        state_next      = S_IDLE;
      end else if (chk_neg || (chk_idx >= ADDR_W'(pool_live))) begin
        done_next       = 1'b1;
        rsp_next.status = ST_RANGE;
        state_next      = S_IDLE;
      end else begin
        rel_idx_next = chk_idx[IDX_W-1:0];
        mem_raddr    = chk_idx[IDX_W-1:0];
        state_next   = S_REL_RD;
      end
    end

    rsp_next.free_count = free_blocks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      head_index  <= '0;
      head_valid  <= (RST_POOL != 0);
      free_blocks <= FC_W'(RST_POOL);
      sweep_ptr   <= '0;
      sweep_n     <= NB_W'(RST_POOL);
      sweep_init  <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      head_index  <= head_index_next;
      head_valid  <= head_valid_next;
      free_blocks <= free_blocks_next;
      sweep_ptr   <= sweep_ptr_next;
      sweep_n     <= sweep_n_next;
      sweep_init  <= sweep_init_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    need     <= need_next;
    aoff     <= aoff_next;
    offs     <= offs_next;
    rel_neg  <= rel_neg_next;
    rel_idx  <= rel_idx_next;
    response <= rsp_next;
  end

  assign busy = (state != S_IDLE);

  // The free list is empty exactly when no block is counted as free.
  assert property (@(posedge clk) disable iff (rst)
    head_valid == (free_blocks != '0))
    else $error("head valid disagrees with free block count");

  assert property (@(posedge clk) disable iff (rst)
    done && (response.status == ST_EMPTY) |-> (response.free_count == '0))
    else $error("empty status reported with free blocks left");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the release sequence");

  assert property (@(posedge clk) disable iff (rst)
    done && (response.status != ST_OK) |-> (response.block_address == '0))
    else $error("failed command returned a block address");

endmodule

/* rtl/fbfl_div.sv */
`timescale 1ns / 1ps

module fbfl_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fbfl_pkg::ADDR_W-1:0] dividend,
  input  logic [fbfl_pkg::BS_W-1:0]   divisor,
  output logic                       done,
  output logic [fbfl_pkg::ADDR_W-1:0] quotient,
  output logic [fbfl_pkg::BS_W-1:0]   remainder
);
  import fbfl_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [BS_W-1:0]  rem;
  logic [ADDR_W-1:0] quo;
  logic [BS_W-1:0]  dsr;
  logic [BS_W:0]    rem_sh;
  logic             ge;
  logic [BS_W:0]    rem_sub;

  // One restoring step per cycle: the dividend shifts out of quo while
  // quotient bits shift in.
  always_comb begin
    rem_sh  = {rem, quo[ADDR_W-1]};
    ge      = (rem_sh >= {1'b0, dsr});
    rem_sub = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(ADDR_W - 1);
        rem <= '0;
        quo <= dividend;
        dsr <= divisor;
      end else if (run) begin
        rem <= ge ? rem_sub[BS_W-1:0] : rem_sh[BS_W-1:0];
        quo <= {quo[ADDR_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* rtl/fbfl_mem.sv */
`timescale 1ns / 1ps

module fbfl_mem #(
  parameter int DEPTH = fbfl_pkg::MAX_BLOCKS_DEF,
  parameter int AW    = $clog2(fbfl_pkg::MAX_BLOCKS_DEF),
  parameter int DW    = $clog2(fbfl_pkg::MAX_BLOCKS_DEF) + 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* test/fbfl_checker.sv */
`timescale 1ns / 1ps

module fbfl_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  fbfl_pkg::fbfl_req_t             request,
  input  logic                            done,
  input  fbfl_pkg::fbfl_rsp_t             response,
  input  logic                            cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              results_pending
);
  import fbfl_pkg::*;

  localparam int DEPTH = MAX_BLOCKS_DEF;

  logic [BS_W-1:0]   blk_size;
  logic [NB_W-1:0]   blk_count;
  logic [ADDR_W-1:0] pool_base;
  logic [ADDR_W-1:0] mem_bytes;

  logic [NB_W-1:0] link_next [DEPTH];
  bit              link_last [DEPTH];
  bit              in_use [DEPTH];
  logic [NB_W-1:0] head;
  bit              head_ok;
  logic [FC_W-1:0] free_left;

  fbfl_rsp_t expected_rsp [$];

  function automatic int unsigned live_pool();
    return (blk_count > DEPTH) ? DEPTH : blk_count;
  endfunction

  function automatic void rechain(int unsigned n);
    for (int i = 0; i < DEPTH; i++) begin
      link_next[i] = (i + 1 < n) ? NB_W'(i + 1) : '0;
      link_last[i] = (i + 1 == n);
      in_use[i] = 1'b0;
    end
    head = '0;
    head_ok = (n != 0);
    free_left = FC_W'(n);
  endfunction

  function automatic fbfl_rsp_t predict(fbfl_req_t req);
    fbfl_rsp_t r;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] mag;
    logic [ADDR_W-1:0] blk_idx;
    logic [63:0] need;
    int unsigned n;
    int unsigned idx;
    r = '0;
    r.status = ST_OK;
    case (req.command)
      CMD_ALLOC: begin
        if (!head_ok) begin
          r.status = ST_EMPTY;
        end else begin
          idx = head;
          head_ok = !link_last[idx];
          head = head_ok ? link_next[idx] : '0;
          link_next[idx] = '0;
          link_last[idx] = 1'b0;
          in_use[idx] = 1'b1;
          if (free_left != 0) free_left = free_left - 1'b1;
          r.block_address = pool_base + ADDR_W'(idx) * ADDR_W'(blk_size);
        end
      end
      CMD_RELEASE: begin
        diff = req.release_address - pool_base;
        mag = diff[ADDR_W-1] ? (~diff + 1'b1) : diff;
        blk_idx = '0;
        if (blk_size == 0) begin
          if (mag != 0) r.status = ST_UNALIGNED;
        end else if (mag % blk_size != 0) begin
          r.status = ST_UNALIGNED;
        end else begin
          blk_idx = mag / blk_size;
        end
        if (r.status == ST_OK) begin
          if ((diff[ADDR_W-1] && mag != 0) || blk_idx >= live_pool()) begin
            r.status = ST_RANGE;
          end else if (!in_use[blk_idx]) begin
            r.status = ST_DOUBLE;
          end else begin
            in_use[blk_idx] = 1'b0;
            link_next[blk_idx] = head;
            link_last[blk_idx] = !head_ok;
            head = NB_W'(blk_idx);
            head_ok = 1'b1;
            free_left = free_left + 1'b1;
          end
        end
      end
      CMD_INIT: begin
        n = live_pool();
        need = 64'(n) * (64'(blk_size) + 64'd4);
        if (64'(mem_bytes) < need) r.status = ST_NOMEM;
        else rechain(n);
      end
      default: begin
      end
    endcase
    r.free_count = free_left;
    return r;
  endfunction

  task automatic flag(input string field, input logic [ADDR_W-1:0] want,
                      input logic [ADDR_W-1:0] got);
    $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    fbfl_rsp_t want;
    if (rst) begin
      blk_size = BLOCK_SIZE_RST;
      blk_count = NUM_BLOCKS_RST;
      pool_base = BASE_ADDRESS_RST;
      mem_bytes = MEMORY_SIZE_RST;
      rechain(live_pool());
      expected_rsp.delete();
      mismatch_count = 0;
    end else begin
      if (done === 1'b1) begin
        if (expected_rsp.size() == 0) begin
          flag("unexpected beat status", '0, ADDR_W'(response.status));
        end else begin
          want = expected_rsp.pop_front();
          if (response.status !== want.status)
            flag("status", ADDR_W'(want.status), ADDR_W'(response.status));
          if (response.block_address !== want.block_address)
            flag("block_address", want.block_address, response.block_address);
          if (response.free_count !== want.free_count)
            flag("free_count", ADDR_W'(want.free_count), ADDR_W'(response.free_count));
        end
      end
      if (start === 1'b1 && busy === 1'b0) expected_rsp.push_back(predict(request));
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_BLOCK_SIZE:   blk_size = cfg_data[BS_W-1:0];
          REG_NUM_BLOCKS:   blk_count = cfg_data[NB_W-1:0];
          REG_BASE_ADDRESS: pool_base = cfg_data[ADDR_W-1:0];
          REG_MEMORY_SIZE:  mem_bytes = cfg_data[ADDR_W-1:0];
          default: begin
          end
        endcase
      end
    end
    results_pending = expected_rsp.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import fbfl_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 112;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  fbfl_req_t             request = '0;
  logic                  done;
  fbfl_rsp_t             response;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatch_count;
  int                    results_pending;
  int                    cycle_count = 0;

  logic [BS_W-1:0]   cur_bs = BLOCK_SIZE_RST;
  logic [NB_W-1:0]   cur_nb = NUM_BLOCKS_RST;
  logic [ADDR_W-1:0] cur_base = BASE_ADDRESS_RST;

  fixed_block_free_list_allocator i_dut (.*);
  fbfl_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
    start <= 1'b1;
    request <= '{command: cmd, release_address: addr};
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (results_pending != 0 || busy !== 1'b0);
  endtask

  task automatic set_config(input logic [BS_W-1:0] bs, input logic [NB_W-1:0] nb,
                            input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] mem);
    cfg_we <= 1'b1;
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data <= CFG_DATA_W'(bs);
    @(negedge clk);
    cfg_index <= REG_NUM_BLOCKS;
    cfg_data <= CFG_DATA_W'(nb);
    @(negedge clk);
    cfg_index <= REG_BASE_ADDRESS;
    cfg_data <= base;
    @(negedge clk);
    cfg_index <= REG_MEMORY_SIZE;
    cfg_data <= mem;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_bs = bs;
    cur_nb = nb;
    cur_base = base;
  endtask

  function automatic int unsigned pool_blocks();
    return (cur_nb > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : cur_nb;
  endfunction

  // Mostly aligned addresses, often of low-index blocks, where allocations land.
  function automatic logic [ADDR_W-1:0] pick_release();
    int unsigned pool = pool_blocks();
    int unsigned near = (pool < 16) ? pool : 16;
    int unsigned idx = 0;
    int unsigned sel = $urandom_range(0, 99);
    logic [ADDR_W-1:0] step;
    if (pool != 0)
      idx = $urandom_range(0, 1) ? $urandom_range(0, near - 1) : $urandom_range(0, pool - 1);
    step = ADDR_W'(idx) * ADDR_W'(cur_bs);
    if (sel < 70) return cur_base + step;
    if (sel < 78) return cur_base + step + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
    if (sel < 84) return cur_base + ADDR_W'(pool + $urandom_range(0, 3)) * ADDR_W'(cur_bs);
    if (sel < 90) return cur_base - ADDR_W'(idx + 1) * ADDR_W'(cur_bs);
    if (sel < 95) return cur_base + 32'h8000_0000;
    return $urandom;
  endfunction

  initial begin
    int unsigned sel;
    int unsigned gap_pct;
    logic [BS_W-1:0] bs;
    logic [NB_W-1:0] nb;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] mem;
    logic [63:0] need;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_idle();

    issue(CMD_ALLOC, 32'hFFFF_FFFF);
    issue(CMD_ALLOC, 32'h0);
    issue(CMD_RELEASE, 32'd0);
    issue(CMD_RELEASE, 32'd0);
    issue(CMD_RELEASE, 32'd1);
    issue(CMD_RELEASE, 32'd16384);
    issue(CMD_RELEASE, 32'hFFFF_FFC0);
    issue(CMD_RELEASE, 32'h8000_0000);
    issue(CMD_RELEASE, 32'd128);
    issue(CMD_UNUSED, 32'hA5A5_5A5A);
    issue(CMD_INIT, 32'h0);
    wait_idle();
    set_config(13'd64, 9'd256, 32'd0, 32'd17407);
    issue(CMD_INIT, 32'h0);
    issue(CMD_ALLOC, 32'h0);
    wait_idle();
    set_config(13'd0, 9'd1, 32'hFFFF_FFFF, 32'd4);
    issue(CMD_INIT, 32'h0);
    issue(CMD_ALLOC, 32'h0);
    issue(CMD_ALLOC, 32'h0);
    issue(CMD_RELEASE, 32'hFFFF_FFFF);
    issue(CMD_RELEASE, 32'h0);
    wait_idle();
    set_config(13'd4096, 9'd511, 32'hFFFF_F000, 32'hFFFF_FFFF);
    issue(CMD_INIT, 32'h0);
    issue(CMD_ALLOC, 32'h0);
    issue(CMD_ALLOC, 32'h0);
    issue(CMD_RELEASE, 32'h0);
    wait_idle();
    set_config(13'd8, 9'd0, 32'd0, 32'd0);
    issue(CMD_INIT, 32'h0);
    issue(CMD_ALLOC, 32'h0);
    issue(CMD_RELEASE, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      sel = $urandom_range(0, 99);
      if (sel < 60) bs = BS_W'($urandom_range(1, 64));
      else if (sel < 75) bs = BS_W'($urandom_range(65, 4096));
      else if (sel < 83) bs = 13'd4096;
      else if (sel < 90) bs = 13'd0;
      else if (sel < 95) bs = 13'd1;
      else bs = BS_W'($urandom_range(0, 8191));
      sel = $urandom_range(0, 99);
      if (sel < 50) nb = NB_W'($urandom_range(1, 16));
      else if (sel < 70) nb = NB_W'($urandom_range(17, 256));
      else if (sel < 80) nb = 9'd256;
      else if (sel < 85) nb = 9'd0;
      else if (sel < 90) nb = 9'd1;
      else nb = NB_W'($urandom_range(257, 511));
      sel = $urandom_range(0, 99);
      if (sel < 70) base = $urandom;
      else if (sel < 85) base = 32'd0;
      else base = 32'hFFFF_F000 + $urandom_range(0, 4095);
      need = 64'((nb > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : nb) * (64'(bs) + 64'd4);
      sel = $urandom_range(0, 99);
      if (sel < 60) mem = 32'hFFFF_FFFF;
      else if (sel < 75) mem = need[ADDR_W-1:0];
      else if (sel < 85) mem = (need == 0) ? 32'd0 : need[ADDR_W-1:0] - 1'b1;
      else if (sel < 95) mem = $urandom;
      else mem = 32'd0;
      set_config(bs, nb, base, mem);
      if (p == 0 || $urandom_range(0, 4) != 0) issue(CMD_INIT, $urandom);
      gap_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 3) * 15;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) issue(CMD_ALLOC, $urandom);
        else if (sel < 90) issue(CMD_RELEASE, pick_release());
        else if (sel < 94) issue(CMD_INIT, $urandom);
        else issue(CMD_UNUSED, $urandom);
        if ($urandom_range(1, 100) <= gap_pct) idle_burst($urandom_range(1, 6));
      end
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fbfl_pkg.sv
rtl/fbfl_div.sv
rtl/fbfl_mem.sv
rtl/fixed_block_free_list_allocator.sv
test/fbfl_checker.sv
test/tb.sv
